// File: hdl/ca80_pkg.sv
`default_nettype none

package ca80_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WideW = 16;
  localparam int unsigned CmdW  = 4;

  // codes 12 to 15 are no-ops
  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 4'd0,
    CMD_ADC = 4'd1,
    CMD_SUB = 4'd2,
    CMD_SBB = 4'd3,
    CMD_AND = 4'd4,
    CMD_XOR = 4'd5,
    CMD_OR  = 4'd6,
    CMD_INR = 4'd7,
    CMD_DCR = 4'd8,
    CMD_INX = 4'd9,
    CMD_DCX = 4'd10,
    CMD_DAD = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] operand;
    logic [WideW-1:0] pair_value;
    logic [WideW-1:0] hl_value;
    logic             carry_in;
    logic             zero_in;
    logic             sign_in;
    logic             parity_in;
    logic             aux_in;
  } alu_in_t;

  typedef struct packed {
    logic [ByteW-1:0] result_byte;
    logic [WideW-1:0] result_wide;
    logic             carry_out;
    logic             zero_out;
    logic             sign_out;
    logic             parity_out;
    logic             aux_out;
  } alu_out_t;

endpackage

`default_nettype wire

// File: hdl/cpu8080_alu_core.sv
// path: the input register captures the transaction, then the result register
//   captures its result; a held result can delay the second step
// throughput: one transaction per cycle; the input register and the result
//   register form a two-stage pipeline, stalled only by a held result
// reset: asynchronous active-low reset empties both stages; payload
//   registers are not reset
`default_nettype none

module cpu8080_alu_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  ca80_pkg::alu_in_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ca80_pkg::alu_out_t  out_data_o
);
  import ca80_pkg::*;

  logic     s1_valid_q;
  alu_in_t  s1_q;
  logic     out_valid_q;
  alu_out_t out_q;
  alu_out_t res;
  logic     adv;

  // result register can take a new value when empty or being drained
  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = s1_valid_q & ~adv;

  ca80_alu_logic u_logic (
    .op_i  (s1_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) s1_q <= in_data_i;
    if (adv && s1_valid_q) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && adv |=> out_valid_q)
    else $error("stage one transaction not moved to result register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && s1_valid_q)
    else $error("input stalled without a blocked result");

  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_q))
    else $error("blocked stage one transaction lost");

endmodule

`default_nettype wire

// File: hdl/ca80_alu_logic.sv
`default_nettype none

module ca80_alu_logic (
  input  ca80_pkg::alu_in_t  op_i,
  output ca80_pkg::alu_out_t res_o
);
  import ca80_pkg::*;

  logic             is_sub;
  logic             add_cin;
  logic [ByteW-1:0] add_b;
  logic [ByteW:0]   add_sum;
  logic [4:0]       nib_sum;
  logic [ByteW-1:0] inc_byte;
  logic [ByteW-1:0] dec_byte;
  logic [WideW:0]   dad_sum;
  logic [ByteW-1:0] rb;
  logic             szp;

  // one shared byte adder for add, adc, sub and sbb
  always_comb begin
    is_sub  = (op_i.command == CMD_SUB) || (op_i.command == CMD_SBB);
    add_b   = is_sub ? ~op_i.operand : op_i.operand;
    unique case (op_i.command)
      CMD_ADC: add_cin = op_i.carry_in;
      CMD_SUB: add_cin = 1'b1;
      CMD_SBB: add_cin = ~op_i.carry_in;
      default: add_cin = 1'b0;
    endcase
    add_sum = {1'b0, op_i.acc} + {1'b0, add_b} + {{ByteW{1'b0}}, add_cin};
    nib_sum = {1'b0, op_i.acc[3:0]} + {1'b0, add_b[3:0]} + {4'b0, add_cin};
  end

  assign inc_byte = op_i.operand + 8'd1;
  assign dec_byte = op_i.operand - 8'd1;
  assign dad_sum  = {1'b0, op_i.pair_value} + {1'b0, op_i.hl_value};

  always_comb begin
    rb              = op_i.acc;
    szp             = 1'b0;
    res_o.result_wide = '0;
    res_o.carry_out = op_i.carry_in;
    res_o.aux_out   = op_i.aux_in;
    unique case (op_i.command)
      CMD_ADD, CMD_ADC: begin
        rb              = add_sum[ByteW-1:0];
        res_o.carry_out = add_sum[ByteW];
        res_o.aux_out   = nib_sum[4];
        szp             = 1'b1;
      end
      CMD_SUB, CMD_SBB: begin
        rb              = add_sum[ByteW-1:0];
        res_o.carry_out = ~add_sum[ByteW];
        res_o.aux_out   = nib_sum[4];
        szp             = 1'b1;
      end
      CMD_AND: begin
        rb              = op_i.acc & op_i.operand;
        res_o.carry_out = 1'b0;
        res_o.aux_out   = op_i.acc[3] | op_i.operand[3];
        szp             = 1'b1;
      end
      CMD_XOR: begin
        rb              = op_i.acc ^ op_i.operand;
        res_o.carry_out = 1'b0;
        res_o.aux_out   = 1'b0;
        szp             = 1'b1;
      end
      CMD_OR: begin
        rb              = op_i.acc | op_i.operand;
        res_o.carry_out = 1'b0;
        res_o.aux_out   = 1'b0;
        szp             = 1'b1;
      end
      CMD_INR: begin
        rb            = inc_byte;
        res_o.aux_out = (inc_byte[3:0] == 4'h0);
        szp           = 1'b1;
      end
      CMD_DCR: begin
        rb            = dec_byte;
        res_o.aux_out = (dec_byte[3:0] != 4'hf);
        szp           = 1'b1;
      end
      CMD_INX: res_o.result_wide = op_i.pair_value + 16'd1;
      CMD_DCX: res_o.result_wide = op_i.pair_value - 16'd1;
      CMD_DAD: begin
        res_o.result_wide = dad_sum[WideW-1:0];
        res_o.carry_out   = dad_sum[WideW];
      end
      default: ;
    endcase
    res_o.result_byte = rb;
    res_o.zero_out    = szp ? (rb == '0) : op_i.zero_in;
    res_o.sign_out    = szp ? rb[ByteW-1] : op_i.sign_in;
    res_o.parity_out  = szp ? ~(^rb) : op_i.parity_in;
  end

endmodule

`default_nettype wire
